// ===== src/dtf_pkg.sv =====
// ----------------------------------------------------------------------------
// dtf_pkg
// Shared widths, character codes, register indexes and power-of-ten tables
// for the decimal text to fixed-point parser.
// ----------------------------------------------------------------------------
package dtf_pkg;

	localparam int GLYPH_W          = 16;
	localparam int DEC_W            = 5;
	localparam int VAL_W            = 64;
	localparam int ACC_W            = 63;
	localparam int POW_W            = 60;
	localparam int MAX_DECIMALS_DEF = 18;

	localparam logic [ACC_W-1:0]   ACC_MAX    = {ACC_W{1'b1}};
	localparam logic [GLYPH_W-1:0] CH_ZERO    = 16'h0030;
	localparam logic [GLYPH_W-1:0] CH_NINE    = 16'h0039;
	localparam logic [GLYPH_W-1:0] CH_MINUS   = 16'h002D;
	localparam logic [GLYPH_W-1:0] PERIOD_RST = 16'h002E;

	typedef enum logic [1:0] {
		REG_PERIOD    = 2'd0,
		REG_DECIMALS  = 2'd1,
		REG_RANGE_MIN = 2'd2,
		REG_RANGE_MAX = 2'd3
	} cfg_reg_t;

	// Everything the scaling pipeline needs once a string has ended.
	typedef struct packed {
		logic             nonempty;
		logic             neg;
		logic             modified;
		logic [DEC_W-1:0] scale;
		logic [ACC_W-1:0] acc;
	} dtf_snap_t;

	function automatic logic [POW_W-1:0] pow10(input logic [DEC_W-1:0] k);
		logic [POW_W-1:0] r;
		case (k)
			5'd1:    r = 60'd10;
			5'd2:    r = 60'd100;
			5'd3:    r = 60'd1000;
			5'd4:    r = 60'd10000;
			5'd5:    r = 60'd100000;
			5'd6:    r = 60'd1000000;
			5'd7:    r = 60'd10000000;
			5'd8:    r = 60'd100000000;
			5'd9:    r = 60'd1000000000;
			5'd10:   r = 60'd10000000000;
			5'd11:   r = 60'd100000000000;
			5'd12:   r = 60'd1000000000000;
			5'd13:   r = 60'd10000000000000;
			5'd14:   r = 60'd100000000000000;
			5'd15:   r = 60'd1000000000000000;
			5'd16:   r = 60'd10000000000000000;
			5'd17:   r = 60'd100000000000000000;
			5'd18:   r = 60'd1000000000000000000;
			default: r = 60'd1;
		endcase
		return r;
	endfunction

	// Largest accumulator value that can be scaled by pow10(k) without overflow.
	function automatic logic [ACC_W-1:0] scale_limit(input logic [DEC_W-1:0] k);
		logic [ACC_W-1:0] r;
		case (k)
			5'd1:    r = 63'd922337203685477580;
			5'd2:    r = 63'd92233720368547758;
			5'd3:    r = 63'd9223372036854775;
			5'd4:    r = 63'd922337203685477;
			5'd5:    r = 63'd92233720368547;
			5'd6:    r = 63'd9223372036854;
			5'd7:    r = 63'd922337203685;
			5'd8:    r = 63'd92233720368;
			5'd9:    r = 63'd9223372036;
			5'd10:   r = 63'd922337203;
			5'd11:   r = 63'd92233720;
			5'd12:   r = 63'd9223372;
			5'd13:   r = 63'd922337;
			5'd14:   r = 63'd92233;
			5'd15:   r = 63'd9223;
			5'd16:   r = 63'd922;
			5'd17:   r = 63'd92;
			5'd18:   r = 63'd9;
			default: r = ACC_MAX;
		endcase
		return r;
	endfunction

endpackage

// ===== src/dtf_if.sv =====
// ----------------------------------------------------------------------------
// dtf_if
// Valid/ready channels for characters in and parsed values out.
// ----------------------------------------------------------------------------
interface dtf_char_if;
	logic                        valid;
	logic                        ready;
	logic [dtf_pkg::GLYPH_W-1:0] glyph;
	logic                        has_glyph;
	logic                        last;

	modport source (output valid, glyph, has_glyph, last, input ready);
	modport sink   (input valid, glyph, has_glyph, last, output ready);
endinterface

interface dtf_result_if;
	logic                             valid;
	logic                             ready;
	logic signed [dtf_pkg::VAL_W-1:0] value;
	logic                             modified;

	modport source (output valid, value, modified, input ready);
	modport sink   (input valid, value, modified, output ready);
endinterface

// ===== src/dtf_scan.sv =====
// ----------------------------------------------------------------------------
// dtf_scan
// Per-character parse state: digit accumulation with saturation, separator
// window and sign tracking. Hands a snapshot on at the end of each string.
// ----------------------------------------------------------------------------
module dtf_scan (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  logic [dtf_pkg::GLYPH_W-1:0] glyph,
	input  logic                        has_glyph,
	input  logic                        last,
	input  logic [dtf_pkg::GLYPH_W-1:0] period,
	input  logic [dtf_pkg::DEC_W-1:0]   dec_eff,
	output dtf_pkg::dtf_snap_t          snap,
	output logic                        snap_load
);
	import dtf_pkg::*;

	localparam logic [DEC_W-1:0] WIN_MAX = {DEC_W{1'b1}};

	logic [ACC_W-1:0] acc_q, n_acc;
	logic             sat_q, n_sat;
	logic             seen_q, n_seen;
	logic [DEC_W-1:0] after_q, n_after;
	logic [DEC_W-1:0] window_q, n_window;
	logic             minus_q, n_minus;
	logic             first_q, n_first;
	logic             trunc_q, n_trunc;
	logic [ACC_W+3:0] times10;
	logic             is_digit;
	logic [DEC_W-1:0] nd;

	assign times10 = (ACC_W+4)'({acc_q, 3'b000}) + (ACC_W+4)'({acc_q, 1'b0})
		+ (ACC_W+4)'(glyph[3:0]);
	assign is_digit = (glyph >= CH_ZERO) && (glyph <= CH_NINE);

	always_comb begin
		logic skip;
		skip     = 1'b0;
		n_acc    = acc_q;
		n_sat    = sat_q;
		n_seen   = seen_q;
		n_after  = after_q;
		n_window = window_q;
		n_minus  = minus_q;
		n_first  = first_q;
		n_trunc  = trunc_q;
		if (has_glyph) begin
			if (!first_q) begin
				n_first = 1'b1;
				n_minus = (glyph == CH_MINUS);
			end
			if (!sat_q) begin
				// Once a separator is seen, only dec_eff more characters are kept.
				if (seen_q) begin
					n_window = (window_q == WIN_MAX) ? window_q : window_q + 1'b1;
					if (n_window > dec_eff) begin
						n_trunc = 1'b1;
						skip    = 1'b1;
					end
				end
				if (!skip) begin
					if (glyph == CH_MINUS) begin
						if (seen_q) n_after = after_q + 1'b1;
					end else if (glyph == period) begin
						n_seen  = 1'b1;
						n_after = '0;
					end else begin
						if (seen_q) n_after = after_q + 1'b1;
						if (is_digit) begin
							if (|times10[ACC_W+3:ACC_W]) begin
								n_acc = ACC_MAX;
								n_sat = 1'b1;
							end else begin
								n_acc = times10[ACC_W-1:0];
							end
						end
					end
				end
			end
		end
	end

	assign nd = n_seen ? n_after : '0;

	always_comb begin
		snap.nonempty = n_first;
		snap.neg      = n_minus;
		snap.modified = n_trunc | n_sat;
		snap.scale    = (nd < dec_eff) ? dec_eff - nd : '0;
		snap.acc      = n_acc;
	end

	assign snap_load = fire && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			sat_q    <= 1'b0;
			seen_q   <= 1'b0;
			after_q  <= '0;
			window_q <= '0;
			minus_q  <= 1'b0;
			first_q  <= 1'b0;
			trunc_q  <= 1'b0;
		end else if (fire) begin
			if (last) begin
				acc_q    <= '0;
				sat_q    <= 1'b0;
				seen_q   <= 1'b0;
				after_q  <= '0;
				window_q <= '0;
				minus_q  <= 1'b0;
				first_q  <= 1'b0;
				trunc_q  <= 1'b0;
			end else begin
				acc_q    <= n_acc;
				sat_q    <= n_sat;
				seen_q   <= n_seen;
				after_q  <= n_after;
				window_q <= n_window;
				minus_q  <= n_minus;
				first_q  <= n_first;
				trunc_q  <= n_trunc;
			end
		end
	end

`ifndef SYNTHESIS
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last |=> acc_q == '0 && !first_q && !sat_q && !seen_q)
		else $error("parse state not cleared after the last character");

	a_sat_pins_acc: assert property (@(posedge clk) disable iff (!arst_n)
		sat_q |-> acc_q == ACC_MAX)
		else $error("saturated flag set with accumulator below maximum");

	a_window_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!seen_q |-> window_q == '0 && after_q == '0)
		else $error("decimal counters moved before a separator");
`endif

endmodule

// ===== src/dtf_finish.sv =====
// ----------------------------------------------------------------------------
// dtf_finish
// Scales a finished accumulator by a power of ten with saturation, applies
// the sign and clamps to the configured range. Four stages plus the result
// register; the 63 x 60 bit product is built from three 32-bit products.
// ----------------------------------------------------------------------------
module dtf_finish (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             snap_load,
	input  dtf_pkg::dtf_snap_t               snap,
	input  logic signed [dtf_pkg::VAL_W-1:0] range_min,
	input  logic signed [dtf_pkg::VAL_W-1:0] range_max,
	output logic                             s1_ready,
	dtf_result_if.source                     results
);
	import dtf_pkg::*;

	typedef struct packed {
		logic nonempty;
		logic neg;
		logic modified;
	} flags_t;

	logic             v_s1, v_s2, v_s3, v_s4;
	logic             rdy2, rdy3, rdy4, out_free;
	dtf_snap_t        snap_s1;

	logic [ACC_W-1:0] acc_s2, acc_s3;
	logic [POW_W-1:0] m_s2, m_s3;
	logic             ovf_s2, ovf_s3, ovf_s4;
	logic [VAL_W-1:0] part_s2, part_s3, prod_s4;
	flags_t           fl_s2, fl_s3, fl_s4;

	logic [POW_W-1:0]       m_c;
	logic [VAL_W-1:0]       p0_c;
	logic [ACC_W-1:0]       p1_c;
	logic [VAL_W-1:0]       p2_c;
	logic [ACC_W-1:0]       mag;
	logic [VAL_W-1:0]       neg_v;
	logic signed [VAL_W-1:0] value_c;
	logic                   mod_c;

	logic                   res_valid_q;
	logic signed [VAL_W-1:0] value_q;
	logic                   mod_q;

	assign out_free = !res_valid_q || results.ready;
	assign rdy4     = !v_s4 || out_free;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign s1_ready = !v_s1 || rdy2;

	assign m_c  = pow10(snap_s1.scale);
	assign p0_c = snap_s1.acc[31:0] * m_c[31:0];
	assign p1_c = acc_s2[ACC_W-1:32] * m_s2[31:0];
	assign p2_c = acc_s3[31:0] * m_s3[POW_W-1:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (s1_ready) v_s1 <= snap_load;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (out_free) res_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready && snap_load) snap_s1 <= snap;
		if (rdy2 && v_s1) begin
			acc_s2  <= snap_s1.acc;
			m_s2    <= m_c;
			ovf_s2  <= snap_s1.acc > scale_limit(snap_s1.scale);
			part_s2 <= p0_c;
			fl_s2   <= '{snap_s1.nonempty, snap_s1.neg, snap_s1.modified};
		end
		if (rdy3 && v_s2) begin
			acc_s3  <= acc_s2;
			m_s3    <= m_s2;
			ovf_s3  <= ovf_s2;
			part_s3 <= part_s2 + {p1_c[31:0], 32'b0};
			fl_s3   <= fl_s2;
		end
		if (rdy4 && v_s3) begin
			ovf_s4  <= ovf_s3;
			prod_s4 <= part_s3 + {p2_c[31:0], 32'b0};
			fl_s4   <= fl_s3;
		end
		if (out_free && v_s4) begin
			value_q <= value_c;
			mod_q   <= mod_c;
		end
	end

	// Without overflow the scaled value fits in 63 bits, so the low bits suffice.
	assign mag   = ovf_s4 ? ACC_MAX : prod_s4[ACC_W-1:0];
	assign neg_v = '0 - {1'b0, mag};

	always_comb begin
		value_c = '0;
		mod_c   = 1'b0;
		if (fl_s4.nonempty) begin
			mod_c = fl_s4.modified | ovf_s4;
			if (fl_s4.neg) begin
				// A saturated negative value goes straight to the floor.
				if (mag == ACC_MAX || $signed(neg_v) < range_min) value_c = range_min;
				else value_c = $signed(neg_v);
			end else begin
				if ($signed({1'b0, mag}) > range_max) value_c = range_max;
				else value_c = $signed({1'b0, mag});
			end
		end
	end

	assign results.valid    = res_valid_q;
	assign results.value    = value_q;
	assign results.modified = mod_q;

`ifndef SYNTHESIS
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !rdy2 |=> v_s1 && $stable(snap_s1))
		else $error("first stage changed while stalled");

	a_ovf_needs_scale: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && ovf_s2 |-> m_s2 != POW_W'(1))
		else $error("scale overflow flagged without scaling");

	a_ovf_marks_modified: assert property (@(posedge clk) disable iff (!arst_n)
		out_free && v_s4 && ovf_s4 && fl_s4.nonempty |=> results.modified)
		else $error("scale overflow not reported as modified");
`endif

endmodule

// ===== src/decimal_text_to_fixed_parser.sv =====
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_parser
// Converts typed decimal text, one character per request, into a signed
// 64-bit fixed-point value with saturation and range clamping.
//
//   channel  dir  payload                         request taken when
//   chars    in   glyph[15:0] has_glyph last       chars.valid && chars.ready
//   results  out  value[63:0] modified             results.valid && results.ready
//   cfg      in   cfg_index[1:0] cfg_data[63:0]    cfg_we
//
// One character is taken per cycle while chars.ready is high; the accumulator
// update is combinational. On the request carrying last, the accepting edge
// loads the first scaling stage; three more stages and the result register
// follow before the result is valid. Characters without last produce no
// result. Reset clears all parse state and restores the register defaults;
// there is no clearing pass. A stalled result stalls the scaling pipeline,
// and chars.ready drops only once its first stage is full.
// ----------------------------------------------------------------------------
module decimal_text_to_fixed_parser #(
	parameter int MAX_DECIMALS = dtf_pkg::MAX_DECIMALS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	dtf_char_if.sink                  chars,
	dtf_result_if.source              results,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [dtf_pkg::VAL_W-1:0] cfg_data
);
	import dtf_pkg::*;

	localparam logic [DEC_W-1:0] DEC_CAP = DEC_W'(MAX_DECIMALS);

	logic [GLYPH_W-1:0]      period_q;
	logic [DEC_W-1:0]        decimals_q;
	logic signed [VAL_W-1:0] range_min_q;
	logic signed [VAL_W-1:0] range_max_q;
	logic [DEC_W-1:0]        dec_eff;
	logic                    fire;
	logic                    s1_ready;
	logic                    snap_load;
	dtf_snap_t               snap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= PERIOD_RST;
			decimals_q  <= '0;
			range_min_q <= {1'b1, {(VAL_W-1){1'b0}}};
			range_max_q <= {1'b0, {(VAL_W-1){1'b1}}};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PERIOD:    period_q    <= cfg_data[GLYPH_W-1:0];
				REG_DECIMALS:  decimals_q  <= cfg_data[DEC_W-1:0];
				REG_RANGE_MIN: range_min_q <= cfg_data;
				REG_RANGE_MAX: range_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign dec_eff     = (decimals_q > DEC_CAP) ? DEC_CAP : decimals_q;
	assign chars.ready = s1_ready;
	assign fire        = chars.valid && chars.ready;

	dtf_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.glyph     (chars.glyph),
		.has_glyph (chars.has_glyph),
		.last      (chars.last),
		.period    (period_q),
		.dec_eff   (dec_eff),
		.snap      (snap),
		.snap_load (snap_load)
	);

	dtf_finish u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.snap_load (snap_load),
		.snap      (snap),
		.range_min (range_min_q),
		.range_max (range_max_q),
		.s1_ready  (s1_ready),
		.results   (results)
	);

endmodule
